@@ rtl/isort_pkg.sv @@
// Shared constants and types of the insertion sorter: widths, states, commands and status.
package isort_pkg;

  localparam int ISORT_DEPTH = 64;
  localparam int VAL_W       = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD
  } isort_state_t;

  typedef enum logic [1:0] {
    RS_TAIL,
    RS_BELOW,
    RS_EMIT
  } isort_rd_sel_t;

  typedef struct packed {
    logic          accept;
    logic          rd_en;
    isort_rd_sel_t rd_sel;
    logic          wr_en;
    logic          wr_shift;
    logic          pos_dec;
    logic          count_inc;
    logic          set_drop;
    logic          k_inc;
    logic          out_load;
    logic          emit_done;
  } isort_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic in_last;
    logic last_held;
    logic gt;
    logic pos_one;
    logic out_free;
    logic emit_final;
  } isort_stat_t;

endpackage

@@ rtl/isort_dp.sv @@
// Datapath of the insertion sorter: ordered store memory, count, pointers and output register.
module isort_dp #(
  parameter int DEPTH = isort_pkg::ISORT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isort_pkg::isort_cmd_t      cmd,
  output isort_pkg::isort_stat_t     stat,
  input  logic [31:0]                in_tdata,
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);
  import isort_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic [CW-1:0]    count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [VAL_W-1:0] val_r;
  logic             last_r;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r;
  logic             out_last_r;
  logic             out_ovf_r;

  // Read address mux.
  always_comb begin
    unique case (cmd.rd_sel)
      RS_TAIL:  rd_addr = AW'(count_r - CW'(1));
      RS_BELOW: rd_addr = pos_r - AW'(2);
      RS_EMIT:  rd_addr = k_r;
      default:  rd_addr = k_r;
    endcase
  end

  assign wr_addr = pos_r;
  assign wr_data = cmd.wr_shift ? rd_data_r : val_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the incoming beat while it is inserted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    if (cmd.accept) begin
      pos_nxt = AW'(count_r);
    end else if (cmd.pos_dec) begin
      pos_nxt = pos_r - AW'(1);
    end
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.set_drop) begin
      drop_nxt = 1'b1;
    end
    if (cmd.k_inc) begin
      k_nxt = k_r + AW'(1);
    end
    if (cmd.emit_done) begin
      count_nxt = '0;
      drop_nxt  = 1'b0;
      k_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      k_r     <= '0;
      pos_r   <= '0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Output register: a result waits here until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rd_data_r;
      out_last_r <= stat.emit_final;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  always_comb begin
    stat.full       = (count_r == CW'(DEPTH));
    stat.empty      = (count_r == '0);
    stat.in_last    = in_tlast;
    stat.last_held  = last_r;
    stat.gt         = ($signed(rd_data_r) > $signed(val_r));
    stat.pos_one    = (pos_r == AW'(1));
    stat.out_free   = !out_valid_r || out_tready;
    stat.emit_final = ((CW'(k_r) + CW'(1)) == count_r);
  end

endmodule

@@ rtl/isort_ctrl.sv @@
// Controller of the insertion sorter: sequences insertion shifts and the sorted readout.
module isort_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  isort_pkg::isort_stat_t  stat,
  output isort_pkg::isort_cmd_t   cmd
);
  import isort_pkg::*;

  isort_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          priority if (stat.full) begin
            state_nxt = stat.in_last ? S_EMIT_RD : S_IDLE;
          end else if (stat.empty) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        priority if (stat.gt && stat.pos_one) begin
          state_nxt = S_PLACE;
        end else if (stat.gt) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = stat.last_held ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        state_nxt = stat.last_held ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        if (stat.out_free) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        state_nxt = stat.emit_final ? S_IDLE : S_EMIT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RS_EMIT;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.full) begin
            cmd.set_drop = 1'b1;
          end else if (!stat.empty) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_TAIL;
          end
        end
      end
      S_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.gt) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
          if (!stat.pos_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_BELOW;
          end
        end else begin
          cmd.count_inc = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.wr_en     = 1'b1;
        cmd.count_inc = 1'b1;
      end
      S_EMIT_RD: begin
        if (stat.out_free) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_EMIT;
        end
      end
      S_EMIT_LD: begin
        cmd.out_load = 1'b1;
        if (stat.emit_final) begin
          cmd.emit_done = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/insertion_sorter_core.sv @@
// Top level of the insertion sorter: controller plus datapath around one ordered store.
//
//   channel | dir | beat content
//   --------+-----+--------------------------------------------------------
//   in_     | in  | tdata = item_value (signed), tlast = is_last
//   out_    | out | tdata = sorted_value (signed), tlast = last_out,
//           |     | tuser = overflow
//
// Sequence: an input beat is accepted, then each stored value greater than it
// is shifted up one place through the single read port and single write port
// of the store, and the beat is written in place; a beat on a full store is
// accepted and dropped. After the last beat each result is read from the
// store, then loaded into the output register.
// Reset clears the count, the drop flag, the readout pointer and the FSM; the
// store itself is not cleared, since only written places are ever read.
// A stalled output holds the readout; no input beat is taken during readout.
module insertion_sorter_core #(
  parameter int DEPTH = isort_pkg::ISORT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic        in_tlast,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);
  import isort_pkg::*;

  isort_cmd_t  cmd;
  isort_stat_t stat;

  // Sequence accept, shift-compare, place and readout.
  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, count, pointers and output register.
  isort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
